// File: rtl/rgba_box_filter_downscale_defines.svh
// Assertion macros shared by the downscaler RTL.
// No dependencies.
`ifndef RGBA_BOX_FILTER_DOWNSCALE_DEFINES_SVH
`define RGBA_BOX_FILTER_DOWNSCALE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define RBF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define RBF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: rtl/rbf_pkg.sv
// Package for the RGBA box-filter downscaler: constants, types and codes.
// No dependencies.
`default_nettype none
package rbf_pkg;
    localparam int MAX_SRC_WIDTH  = 4096;
    localparam int MAX_SRC_HEIGHT = 4096;
    localparam int CHANNELS = 4;
    localparam int DIM_W = 13;
    localparam int POS_W = 12;
    // channel sum: up to 4096*4096*255 fits in 32 bits
    localparam int SUM_W = 32;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_PASS = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_EDGE   = 2'd2;

    typedef logic [CHANNELS-1:0][7:0] pix_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0] sums_t;
endpackage
`default_nettype wire

// File: rtl/rgba_box_filter_downscale.sv
// Top level of the RGBA box-filter downscaler: APB registers, sizing,
// band tracking, column-sum memory, four channel lanes and output register.
// Depends on rbf_pkg, rbf_lane, rbf_divider and the defines header.
// Pass-through: m_valid rises in the cycle after the input transfer, and the
// next pixel is not accepted until m_valid is taken. Downscale: each source
// pixel waits for four band-edge divides on the shared bit-serial divider; a
// pixel closing a block adds a lane mean division before m_valid rises.
// Reset: synchronous active low; registers return to reset values and the
// column sums need no clearing since each band overwrites its first pixel.
`default_nettype none
`include "rgba_box_filter_downscale_defines.svh"
module rgba_box_filter_downscale import rbf_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    input  wire logic [7:0]  s_alpha,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red_out,
    output logic [7:0]       m_green_out,
    output logic [7:0]       m_blue_out,
    output logic [7:0]       m_alpha_out,
    output logic [POS_W-1:0] m_out_col,
    output logic [POS_W-1:0] m_out_row,
    output logic [DIM_W-1:0] m_thumb_width,
    output logic [DIM_W-1:0] m_thumb_height,
    output logic             m_last_pixel
);
    localparam int COL_AW = $clog2(MAX_SRC_WIDTH);
    localparam int DW2 = 2 * DIM_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SZW    = 4'd1;
    localparam logic [3:0] ST_SZH    = 4'd2;
    localparam logic [3:0] ST_RUN    = 4'd3;
    localparam logic [3:0] ST_RD     = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_MEAN   = 4'd6;
    localparam logic [3:0] ST_OUT    = 4'd7;
    localparam logic [3:0] ST_EDGE   = 4'd8;
    localparam logic [3:0] ST_EDGE2  = 4'd9;

    // band edge being computed
    localparam logic [1:0] EK_RIGHT  = 2'd0;
    localparam logic [1:0] EK_BOTTOM = 2'd1;
    localparam logic [1:0] EK_LEFT   = 2'd2;
    localparam logic [1:0] EK_TOP    = 2'd3;

    logic [DIM_W-1:0] src_width_reg, src_height_reg, max_edge_reg;
    logic [3:0]       state_reg;
    logic [1:0]       mode_reg;
    logic [DIM_W-1:0] thumb_w_reg, thumb_h_reg;
    logic [DIM_W-1:0] src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    logic [DIM_W-1:0] right_reg, bottom_reg, left_reg, top_reg;
    pix_t             px_reg;
    logic             first_reg, emit_reg;
    logic [DW2-1:0]   count_reg;
    sums_t            acc_reg;
    logic             m_valid_reg;
    pix_t             o_pix_reg;
    logic [POS_W-1:0] o_col_reg, o_row_reg;
    logic             o_last_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // register read mux
    always_comb begin
        case (paddr[3:2])
            REG_SRC_WIDTH:  prdata = {19'd0, src_width_reg};
            REG_SRC_HEIGHT: prdata = {19'd0, src_height_reg};
            REG_MAX_EDGE:   prdata = {19'd0, max_edge_reg};
            default:        prdata = '0;
        endcase
    end

    // shared divider for sizes and band edges
    logic [DW2-1:0]   dv_num;
    logic [DIM_W-1:0] dv_den;
    logic             dv_start, dv_busy, dv_done;
    logic [DW2-1:0]   dv_quo;
    rbf_divider #(.NUM_W(DW2), .DEN_W(DIM_W)) u_sdiv (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num),
        .den(dv_den), .busy(dv_busy), .done(dv_done), .quo(dv_quo)
    );
    logic [DIM_W-1:0] longer;
    assign longer = (src_width_reg > src_height_reg) ? src_width_reg : src_height_reg;
    logic [DIM_W-1:0] dv_q13;
    assign dv_q13 = dv_quo[DIM_W-1:0];

    // column sum memory
    sums_t            mem [MAX_SRC_WIDTH];
    sums_t            mem_rd_reg;
    logic [COL_AW-1:0] slot;
    assign slot = dst_col_reg[COL_AW-1:0];
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RUN) mem_rd_reg <= mem[slot];
        if (state_reg == ST_ACC) mem[slot] <= acc_reg;
    end

    // lanes
    logic [CHANNELS-1:0] ln_done;
    pix_t ln_mean;
    logic ln_start;
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        rbf_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .start(ln_start), .sum(acc_reg[c]),
            .count(count_reg), .done(ln_done[c]), .mean(ln_mean[c])
        );
    end

    // edge sequence: compute right, bottom, left and top band edges in turn
    logic [1:0] ek_reg;
    logic [DIM_W-1:0] ei;
    assign s_ready = (state_reg == ST_RUN) && !m_valid_reg;

    // accumulate sums
    sums_t acc_next;
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            acc_next[c] = first_reg ? SUM_W'(px_reg[c])
                                    : mem_rd_reg[c] + SUM_W'(px_reg[c]);
        end
    end

    always_comb begin
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = thumb_w_reg;
        ei       = '0;
        case (state_reg)
            ST_IDLE: begin
                dv_start = !cfg_wr && (mode_reg == MODE_DOWN) && !dv_busy && !dv_done;
                dv_num   = DW2'(src_width_reg) * DW2'(max_edge_reg);
                dv_den   = longer;
            end
            ST_SZW: begin
                dv_start = dv_done;
                dv_num   = DW2'(src_height_reg) * DW2'(max_edge_reg);
                dv_den   = longer;
            end
            ST_EDGE: begin
                case (ek_reg)
                    EK_RIGHT: begin ei = dst_col_reg + 1'b1; dv_den = thumb_w_reg; end
                    EK_BOTTOM: begin ei = dst_row_reg + 1'b1; dv_den = thumb_h_reg; end
                    EK_LEFT: begin ei = dst_col_reg; dv_den = thumb_w_reg; end
                    default: begin ei = dst_row_reg; dv_den = thumb_h_reg; end
                endcase
                dv_start = 1'b1;
                dv_num = DW2'(ei) * DW2'((ek_reg[0]) ? src_height_reg : src_width_reg);
            end
            default: ;
        endcase
    end
    assign ln_start = (state_reg == ST_ACC) && emit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= '0;
            src_height_reg <= '0;
            max_edge_reg   <= DIM_W'(256);
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_OFF;
            m_valid_reg    <= 1'b0;
            thumb_w_reg    <= '0;
            thumb_h_reg    <= '0;
            src_col_reg <= '0; src_row_reg <= '0;
            dst_col_reg <= '0; dst_row_reg <= '0;
            ek_reg <= EK_RIGHT;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cfg_wr) begin
                // any write restarts the frame
                case (paddr[3:2])
                    REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                    REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                    REG_MAX_EDGE:   max_edge_reg   <= pwdata[DIM_W-1:0];
                    default: ;
                endcase
                state_reg <= ST_IDLE;
                mode_reg  <= MODE_DOWN; // re-evaluated in ST_IDLE
                src_col_reg <= '0; src_row_reg <= '0;
                dst_col_reg <= '0; dst_row_reg <= '0;
                thumb_w_reg <= '0; thumb_h_reg <= '0;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (mode_reg == MODE_OFF) begin
                            // disabled: take pixels and drop them
                            state_reg <= ST_RUN;
                        end else if (mode_reg == MODE_DOWN && !dv_busy && !dv_done) begin
                            if (src_width_reg == 0 || src_height_reg == 0 ||
                                max_edge_reg == 0 ||
                                32'(src_width_reg) > 32'(MAX_SRC_WIDTH) ||
                                32'(src_height_reg) > 32'(MAX_SRC_HEIGHT)) begin
                                mode_reg <= MODE_OFF;
                            end else if (src_width_reg <= max_edge_reg &&
                                         src_height_reg <= max_edge_reg) begin
                                mode_reg    <= MODE_PASS;
                                thumb_w_reg <= src_width_reg;
                                thumb_h_reg <= src_height_reg;
                                state_reg   <= ST_RUN;
                            end else begin
                                state_reg <= ST_SZW;
                            end
                        end
                    end
                    ST_SZW: if (dv_done) begin
                        thumb_w_reg <= (dv_q13 == 0) ? DIM_W'(1) : dv_q13;
                        state_reg   <= ST_SZH;
                    end
                    ST_SZH: if (dv_done) begin
                        thumb_h_reg <= (dv_q13 == 0) ? DIM_W'(1) : dv_q13;
                        ek_reg      <= EK_RIGHT;
                        state_reg   <= ST_EDGE;
                    end
                    ST_EDGE: state_reg <= ST_EDGE2;
                    ST_EDGE2: if (dv_done) begin
                        case (ek_reg)
                            EK_RIGHT:  right_reg  <= dv_q13;
                            EK_BOTTOM: bottom_reg <= dv_q13;
                            EK_LEFT:   left_reg   <= dv_q13;
                            default:   top_reg    <= dv_q13;
                        endcase
                        if (ek_reg == EK_TOP) state_reg <= ST_RUN;
                        else begin
                            ek_reg <= ek_reg + 1'b1;
                            state_reg <= ST_EDGE;
                        end
                    end
                    ST_RUN: if (s_valid && s_ready) begin
                        px_reg <= {s_alpha, s_blue, s_green, s_red};
                        if (mode_reg == MODE_PASS) begin
                            m_valid_reg <= 1'b1;
                            o_pix_reg   <= {s_alpha, s_blue, s_green, s_red};
                            o_col_reg   <= src_col_reg[POS_W-1:0];
                            o_row_reg   <= src_row_reg[POS_W-1:0];
                            o_last_reg  <= (src_col_reg + 1'b1 == src_width_reg) &&
                                           (src_row_reg + 1'b1 == src_height_reg);
                            if (src_col_reg + 1'b1 >= src_width_reg) begin
                                src_col_reg <= '0;
                                src_row_reg <= (src_row_reg + 1'b1 >= src_height_reg)
                                               ? '0 : src_row_reg + 1'b1;
                            end else src_col_reg <= src_col_reg + 1'b1;
                        end else if (mode_reg == MODE_DOWN) begin
                            first_reg <= (src_row_reg == top_reg) &&
                                         (src_col_reg == left_reg);
                            emit_reg  <= (src_col_reg + 1'b1 == right_reg) &&
                                         (src_row_reg + 1'b1 == bottom_reg);
                            count_reg <= DW2'(right_reg - left_reg) *
                                         DW2'(bottom_reg - top_reg);
                            state_reg <= ST_RD;
                        end
                    end
                    ST_RD: begin
                        acc_reg   <= acc_next;
                        if (count_reg == 0) count_reg <= DW2'(1);
                        state_reg <= ST_ACC;
                    end
                    ST_ACC: state_reg <= emit_reg ? ST_MEAN : ST_OUT;
                    ST_MEAN: if (ln_done[0]) begin
                        m_valid_reg <= 1'b1;
                        o_pix_reg   <= ln_mean;
                        o_col_reg   <= dst_col_reg[POS_W-1:0];
                        o_row_reg   <= dst_row_reg[POS_W-1:0];
                        o_last_reg  <= (dst_col_reg + 1'b1 == thumb_w_reg) &&
                                       (dst_row_reg + 1'b1 == thumb_h_reg);
                        state_reg   <= ST_OUT;
                    end
                    ST_OUT: begin
                        // advance counters, then refresh band edges
                        state_reg <= ST_EDGE;
                        ek_reg    <= EK_RIGHT;
                        if (src_col_reg + 1'b1 >= src_width_reg) begin
                            src_col_reg <= '0;
                            dst_col_reg <= '0;
                            if (src_row_reg + 1'b1 >= src_height_reg) begin
                                src_row_reg <= '0;
                                dst_row_reg <= '0;
                            end else begin
                                src_row_reg <= src_row_reg + 1'b1;
                                if (src_row_reg + 1'b1 >= bottom_reg)
                                    dst_row_reg <= dst_row_reg + 1'b1;
                            end
                        end else begin
                            src_col_reg <= src_col_reg + 1'b1;
                            if (src_col_reg + 1'b1 >= right_reg)
                                dst_col_reg <= dst_col_reg + 1'b1;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red_out      = o_pix_reg[0];
    assign m_green_out    = o_pix_reg[1];
    assign m_blue_out     = o_pix_reg[2];
    assign m_alpha_out    = o_pix_reg[3];
    assign m_out_col      = o_col_reg;
    assign m_out_row      = o_row_reg;
    assign m_thumb_width  = thumb_w_reg;
    assign m_thumb_height = thumb_h_reg;
    assign m_last_pixel   = o_last_reg;

    `RBF_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_valid, !s_ready)
    `RBF_ASSERT_NEXT(a_pass_emits, aclk, aresetn,
        s_valid && s_ready && mode_reg == MODE_PASS, m_valid)
    `RBF_ASSERT_IMP(a_lanes_agree, aclk, aresetn, ln_done[0], ln_done == '1)
endmodule
`default_nettype wire

// File: rtl/rbf_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rbf_pkg.
`default_nettype none
module rbf_divider import rbf_pkg::*; #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 26
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // shift in next numerator bit and try a subtract
    always_comb begin
        trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
            end else if (busy_reg) begin
                if (!diff[DEN_W]) begin
                    r_reg <= diff;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

// File: rtl/rbf_lane.sv
// One channel lane: mean division of a block sum by its pixel count.
// Depends on rbf_pkg and rbf_divider.
`default_nettype none
module rbf_lane import rbf_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] sum,
    input  wire logic [2*DIM_W-1:0] count,
    output logic                  done,
    output logic [7:0]            mean
);
    logic [SUM_W-1:0] quo;
    logic             busy;

    rbf_divider #(.NUM_W(SUM_W), .DEN_W(2*DIM_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(start), .num(sum), .den(count),
        .busy(busy), .done(done), .quo(quo)
    );
    // mean of 8-bit samples never exceeds 255; mean reads zero while busy
    assign mean = busy ? 8'd0 : quo[7:0];
endmodule
`default_nettype wire
